FILE: rtl/core/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared sizes, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package mpbm_pkg;

    localparam int MAX_NODES    = 4096;
    localparam int ALPHABET     = 256;
    localparam int MAX_PATTERNS = 1024;
    localparam int NODE_W       = $clog2(MAX_NODES);
    localparam int SYM_W        = $clog2(ALPHABET);
    localparam int SLOT_W       = $clog2(MAX_PATTERNS);
    localparam int GOTO_DEPTH   = MAX_NODES * ALPHABET;
    localparam int GOTO_AW      = NODE_W + SYM_W;
    localparam int CNT_W        = 11;
    localparam int PID_W        = 11;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_BUILD   = 2'd2;
    localparam logic [1:0] CMD_TEXT    = 2'd3;

    localparam logic [4:0] OP_IDLE     = 5'd0;
    localparam logic [4:0] OP_SWEEP    = 5'd1;
    localparam logic [4:0] OP_DISPATCH = 5'd2;
    localparam logic [4:0] OP_INS_RD   = 5'd3;
    localparam logic [4:0] OP_INS_TRD  = 5'd4;
    localparam logic [4:0] OP_INS_TWR  = 5'd5;
    localparam logic [4:0] OP_SEEN_CLR = 5'd6;
    localparam logic [4:0] OP_B_CHECK  = 5'd7;
    localparam logic [4:0] OP_B_RRD    = 5'd8;
    localparam logic [4:0] OP_B_RCK    = 5'd9;
    localparam logic [4:0] OP_B_POP    = 5'd10;
    localparam logic [4:0] OP_B_P      = 5'd11;
    localparam logic [4:0] OP_B_F      = 5'd12;
    localparam logic [4:0] OP_B_RC     = 5'd13;
    localparam logic [4:0] OP_B_RT     = 5'd14;
    localparam logic [4:0] OP_B_W      = 5'd15;
    localparam logic [4:0] OP_T_RD     = 5'd16;
    localparam logic [4:0] OP_T_CHK    = 5'd17;
    localparam logic [4:0] OP_T_EV     = 5'd18;
    localparam logic [4:0] OP_T_SEEN   = 5'd19;
    localparam logic [4:0] OP_T_NEXT   = 5'd20;
    localparam logic [4:0] OP_EMIT     = 5'd21;

    typedef struct packed {
        logic [4:0] op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       last;
        logic       built;
        logic       ins_blocked;
        logic       ins_full;
        logic       sweep_last;
        logic       seen_last;
        logic       sym_last;
        logic       queue_empty;
        logic       term_nz;
        logic       t_root;
        logic       out_free;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/core/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/mpbm_datapath.sv
// ----------------------------------------------------------------------------
// mpbm_datapath
// Trie, failure links, terminal marks, seen marks, BFS queue and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module mpbm_datapath import mpbm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd_dp,
    output t_dp_status             o_status,
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [PID_W-1:0]  i_pattern_id,
    input  wire logic              i_last,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CNT_W-1:0]       o_match_count,
    output logic                   o_overflow
);
    logic [1:0]         r_cmd;
    logic [SYM_W-1:0]   r_sym;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_last;

    logic [NODE_W-1:0]  r_cursor, n_cursor;
    logic [NODE_W:0]    r_node_total, n_node_total;
    logic [CNT_W-1:0]   r_running, n_running;
    logic               r_overflow, n_overflow;
    logic               r_built, n_built;
    logic [GOTO_AW-1:0] r_sweep, n_sweep;
    logic [NODE_W:0]    r_head, n_head, r_tail, n_tail;
    logic [SYM_W-1:0]   r_i, n_i;
    logic [NODE_W-1:0]  r_p, n_p, r_f, n_f, r_c, n_c, r_t, n_t, r_fl, n_fl;
    logic [CNT_W-1:0]   r_tc, n_tc;
    logic [SLOT_W-1:0]  r_tp, n_tp;
    logic               r_out_valid, n_out_valid;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    logic               r_out_ovf, n_out_ovf;

    logic               g_we;
    logic [GOTO_AW-1:0] g_waddr, g_raddr;
    logic [NODE_W-1:0]  g_wdata, g_rdata;
    logic               f_we;
    logic [NODE_W-1:0]  f_waddr, f_raddr, f_wdata, f_rdata;
    logic               tc_we;
    logic [NODE_W-1:0]  tc_waddr, tc_raddr;
    logic [CNT_W-1:0]   tc_wdata, tc_rdata;
    logic               tp_we;
    logic [NODE_W-1:0]  tp_waddr, tp_raddr;
    logic [SLOT_W-1:0]  tp_wdata, tp_rdata;
    logic               s_we;
    logic [SLOT_W-1:0]  s_waddr, s_raddr;
    logic [0:0]         s_wdata, s_rdata;
    logic               q_we;
    logic [NODE_W-1:0]  q_waddr, q_raddr, q_wdata, q_rdata;

    logic [CNT_W:0]     sum;
    logic               out_free;
    logic [NODE_W-1:0]  child;

    assign out_free = !r_out_valid || !i_stall;
    assign sum      = {1'b0, r_running} + {1'b0, r_tc};
    assign child    = (g_rdata != '0) ? g_rdata : r_node_total[NODE_W-1:0];

    always_comb begin
        n_cursor = r_cursor;  n_node_total = r_node_total; n_running = r_running;
        n_overflow = r_overflow; n_built = r_built; n_sweep = r_sweep;
        n_head = r_head; n_tail = r_tail; n_i = r_i;
        n_p = r_p; n_f = r_f; n_c = r_c; n_t = r_t; n_fl = r_fl;
        n_tc = r_tc; n_tp = r_tp;
        n_out_valid = r_out_valid && i_stall;
        n_out_count = r_out_count; n_out_ovf = r_out_ovf;
        g_we = 1'b0; g_waddr = r_sweep; g_wdata = '0; g_raddr = {r_cursor, r_sym};
        f_we = 1'b0; f_waddr = r_sweep[NODE_W-1:0]; f_wdata = '0; f_raddr = r_t;
        tc_we = 1'b0; tc_waddr = r_sweep[NODE_W-1:0]; tc_wdata = '0; tc_raddr = r_t;
        tp_we = 1'b0; tp_waddr = r_sweep[NODE_W-1:0]; tp_wdata = '0; tp_raddr = r_t;
        s_we = 1'b0; s_waddr = r_sweep[SLOT_W-1:0]; s_wdata = 1'b0; s_raddr = tp_rdata;
        q_we = 1'b0; q_waddr = r_tail[NODE_W-1:0]; q_wdata = '0;
        q_raddr = r_head[NODE_W-1:0];
        case (i_cmd_dp.op)
            OP_SWEEP: begin
                g_we  = 1'b1;
                f_we  = (r_sweep[GOTO_AW-1:NODE_W] == '0);
                tc_we = f_we;
                tp_we = f_we;
                s_we  = (r_sweep[GOTO_AW-1:SLOT_W] == '0);
                n_sweep = r_sweep + 1'b1;
            end
            OP_DISPATCH: begin
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_node_total = (NODE_W+1)'(1);
                        n_cursor = '0; n_running = '0;
                        n_overflow = 1'b0; n_built = 1'b0; n_sweep = '0;
                    end
                    CMD_BUILD: begin
                        n_cursor = '0; n_running = '0; n_sweep = '0;
                    end
                    default: ;
                endcase
            end
            OP_INS_RD: begin
                if (g_rdata == '0 && r_node_total >= (NODE_W+1)'(MAX_NODES)) begin
                    n_overflow = 1'b1;
                    n_cursor = '0;
                end else begin
                    if (g_rdata == '0) begin
                        g_we = 1'b1;
                        g_waddr = {r_cursor, r_sym};
                        g_wdata = child;
                        n_node_total = r_node_total + 1'b1;
                    end
                    n_cursor = child;
                    n_c = child;
                end
            end
            OP_INS_TRD: tc_raddr = r_c;
            OP_INS_TWR: begin
                tc_we = 1'b1; tc_waddr = r_c;
                tc_wdata = (tc_rdata == COUNT_MAX) ? tc_rdata : tc_rdata + 1'b1;
                tp_we = 1'b1; tp_waddr = r_c; tp_wdata = r_slot;
                n_cursor = '0;
            end
            OP_SEEN_CLR: begin
                s_we = 1'b1;
                n_sweep = r_sweep + 1'b1;
            end
            OP_B_CHECK: begin
                n_built = 1'b1;
                n_i = '0; n_head = '0; n_tail = '0;
            end
            OP_B_RRD: g_raddr = {{NODE_W{1'b0}}, r_i};
            OP_B_RCK: begin
                if (g_rdata != '0) begin
                    q_we = 1'b1; q_wdata = g_rdata;
                    n_tail = r_tail + 1'b1;
                end
                n_i = r_i + 1'b1;
            end
            OP_B_POP: begin
                if (r_head != r_tail) begin
                    n_head = r_head + 1'b1;
                end
            end
            OP_B_P: begin
                n_p = q_rdata;
                f_raddr = q_rdata;
            end
            OP_B_F: begin
                n_f = f_rdata;
                n_i = '0;
            end
            OP_B_RC: g_raddr = {r_p, r_i};
            OP_B_RT: begin
                n_c = g_rdata;
                g_raddr = {r_f, r_i};
            end
            OP_B_W: begin
                if (r_c != '0) begin
                    f_we = 1'b1; f_waddr = r_c; f_wdata = g_rdata;
                    if (r_tail < (NODE_W+1)'(MAX_NODES)) begin
                        q_we = 1'b1; q_wdata = r_c;
                        n_tail = r_tail + 1'b1;
                    end
                end else begin
                    g_we = 1'b1; g_waddr = {r_p, r_i}; g_wdata = g_rdata;
                end
                n_i = r_i + 1'b1;
            end
            OP_T_RD: begin
                n_cursor = g_rdata;
                n_t = g_rdata;
            end
            OP_T_EV: begin
                n_tc = tc_rdata; n_tp = tp_rdata; n_fl = f_rdata;
            end
            OP_T_SEEN: begin
                if (!s_rdata[0]) begin
                    n_running = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
                    s_we = 1'b1; s_waddr = r_tp; s_wdata = 1'b1;
                end
            end
            OP_T_NEXT: n_t = r_fl;
            OP_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_running;
                    n_out_ovf = r_overflow;
                    n_running = '0; n_cursor = '0; n_sweep = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0; r_node_total <= (NODE_W+1)'(1); r_running <= '0;
            r_overflow <= 1'b0; r_built <= 1'b0; r_sweep <= '0;
            r_head <= '0; r_tail <= '0; r_out_valid <= 1'b0;
        end else begin
            r_cursor <= n_cursor; r_node_total <= n_node_total; r_running <= n_running;
            r_overflow <= n_overflow; r_built <= n_built; r_sweep <= n_sweep;
            r_head <= n_head; r_tail <= n_tail; r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.op == OP_IDLE && i_valid) begin
            r_cmd  <= i_cmd;
            r_sym  <= i_data_byte;
            r_slot <= i_pattern_id[SLOT_W-1:0];
            r_last <= i_last;
        end
        r_i <= n_i; r_p <= n_p; r_f <= n_f; r_c <= n_c; r_t <= n_t; r_fl <= n_fl;
        r_tc <= n_tc; r_tp <= n_tp;
        r_out_count <= n_out_count; r_out_ovf <= n_out_ovf;
    end

    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
        .i_clk, .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
        .i_clk, .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata));
    mpbm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_tcnt (
        .i_clk, .i_we(tc_we), .i_waddr(tc_waddr), .i_wdata(tc_wdata),
        .i_raddr(tc_raddr), .o_rdata(tc_rdata));
    mpbm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_tpat (
        .i_clk, .i_we(tp_we), .i_waddr(tp_waddr), .i_wdata(tp_wdata),
        .i_raddr(tp_raddr), .o_rdata(tp_rdata));
    mpbm_ram #(.WIDTH(1), .DEPTH(MAX_PATTERNS)) u_seen (
        .i_clk, .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));
    mpbm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .i_clk, .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata));

    always_comb begin
        o_status.cmd         = r_cmd;
        o_status.last        = r_last;
        o_status.built       = r_built;
        o_status.ins_blocked = r_built || r_overflow;
        o_status.ins_full    = (g_rdata == '0) && (r_node_total >= (NODE_W+1)'(MAX_NODES));
        o_status.sweep_last  = (r_sweep == '1);
        o_status.seen_last   = (r_sweep[SLOT_W-1:0] == '1);
        o_status.sym_last    = (r_i == '1);
        o_status.queue_empty = (r_head == r_tail);
        o_status.term_nz     = (tc_rdata != '0);
        o_status.t_root      = (r_t == '0);
        o_status.out_free    = out_free;
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;
    assign o_overflow    = r_out_ovf;
endmodule
`default_nettype wire

FILE: rtl/core/mpbm_ctrl.sv
// ----------------------------------------------------------------------------
// mpbm_ctrl
// Sequencer for clear sweep, insertion, breadth-first build and text walk.
// ----------------------------------------------------------------------------
`default_nettype none
module mpbm_ctrl import mpbm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd_dp
);
    localparam logic [4:0] S_IDLE = OP_IDLE;
    logic [4:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_valid) n_state = OP_DISPATCH;
            OP_SWEEP:    if (i_status.sweep_last) n_state = S_IDLE;
            OP_DISPATCH: begin
                case (i_status.cmd)
                    CMD_CLEAR:   n_state = OP_SWEEP;
                    CMD_PATTERN: n_state = i_status.ins_blocked ? S_IDLE : OP_INS_RD;
                    CMD_BUILD:   n_state = OP_SEEN_CLR;
                    default:     n_state = OP_T_RD;
                endcase
            end
            OP_INS_RD:   n_state = (!i_status.ins_full && i_status.last) ? OP_INS_TRD
                                                                          : S_IDLE;
            OP_INS_TRD:  n_state = OP_INS_TWR;
            OP_INS_TWR:  n_state = S_IDLE;
            OP_SEEN_CLR: if (i_status.seen_last)
                             n_state = (i_status.cmd == CMD_BUILD) ? OP_B_CHECK : S_IDLE;
            OP_B_CHECK:  n_state = i_status.built ? S_IDLE : OP_B_RRD;
            OP_B_RRD:    n_state = OP_B_RCK;
            OP_B_RCK:    n_state = i_status.sym_last ? OP_B_POP : OP_B_RRD;
            OP_B_POP:    n_state = i_status.queue_empty ? S_IDLE : OP_B_P;
            OP_B_P:      n_state = OP_B_F;
            OP_B_F:      n_state = OP_B_RC;
            OP_B_RC:     n_state = OP_B_RT;
            OP_B_RT:     n_state = OP_B_W;
            OP_B_W:      n_state = i_status.sym_last ? OP_B_POP : OP_B_RC;
            OP_T_RD:     n_state = OP_T_CHK;
            OP_T_CHK:    n_state = OP_T_EV;
            OP_T_EV:     n_state = i_status.term_nz ? OP_T_SEEN : OP_T_NEXT;
            OP_T_SEEN:   n_state = OP_T_NEXT;
            OP_T_NEXT: begin
                if (!i_status.t_root) n_state = OP_T_CHK;
                else n_state = i_status.last ? OP_EMIT : S_IDLE;
            end
            OP_EMIT:     if (i_status.out_free) n_state = OP_SEEN_CLR;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cmd_dp.op = r_state;
endmodule
`default_nettype wire

FILE: rtl/core/multi_pattern_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_core
// Aho-Corasick engine over byte symbols with a one-result-per-text output.
// ----------------------------------------------------------------------------
// After reset and after every clear item the block sweeps the goto memory,
// one entry a cycle, and takes no item meanwhile. A pattern byte looks up
// its goto entry; a byte that ends a pattern also updates its terminal
// count. A build item clears the seen marks, then visits each root symbol
// and each trie node, bound by the single goto read port. A text byte
// reads its goto entry, then walks its failure chain node by node; the last
// byte of a text adds the result hand-off and a seen-mark clear.
`default_nettype none
module multi_pattern_byte_matcher_core import mpbm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [PID_W-1:0]  i_pattern_id,
    input  wire logic              i_last,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [CNT_W-1:0]       o_match_count,
    output logic                   o_overflow
);
    t_dp_cmd    cmd_dp;
    t_dp_status status;

    mpbm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_status(status), .o_cmd_dp(cmd_dp));

    mpbm_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd_dp(cmd_dp), .o_status(status),
        .i_valid, .i_cmd, .i_data_byte, .i_pattern_id, .i_last,
        .o_valid, .i_stall, .o_match_count, .o_overflow);
endmodule
`default_nettype wire

FILE: bench/tb_multi_pattern_byte_matcher_core.sv
// ----------------------------------------------------------------------------
// tb_multi_pattern_byte_matcher_core
// Self-checking bench for the Aho-Corasick matcher core.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own trie, failure links and seen marks and
// predicts the match count of every finished text. The bench covers these
// cases: directed patterns and texts, and a random pattern set that is built
// and then searched. Sender idling and receiver stalls change from phase to
// phase.
// ----------------------------------------------------------------------------
`default_nettype none

class match_scoreboard;
    typedef struct packed {
        logic [10:0] count;
        logic        ovf;
    } t_match_res;

    logic [11:0] trie_next [int];
    logic [11:0] fail_of   [4096];
    logic [10:0] term_cnt  [4096];
    logic [9:0]  term_slot [4096];
    bit          slot_seen [1024];
    int          node_cnt;
    int          cursor;
    int          found;
    bit          full;
    bit          built;
    t_match_res  pending_q [$];
    int          n_errors;
    int          n_results;
    int          n_hits;

    function void wipe();
        trie_next.delete();
        foreach (fail_of[i]) begin
            fail_of[i] = '0;
            term_cnt[i] = '0;
            term_slot[i] = '0;
        end
        foreach (slot_seen[i]) slot_seen[i] = 0;
        node_cnt = 1;
        cursor = 0;
        found = 0;
        full = 0;
        built = 0;
    endfunction

    function new();
        wipe();
        n_errors = 0;
        n_results = 0;
        n_hits = 0;
    endfunction

    function int edge_to(int n, int s);
        int key;
        key = n * 256 + s;
        return trie_next.exists(key) ? int'(trie_next[key]) : 0;
    endfunction

    function void insert_sym(int s, logic [10:0] pid, bit fin);
        int child;
        if (built || full) return;
        child = edge_to(cursor, s);
        if (child == 0) begin
            if (node_cnt >= 4096) begin
                full = 1;
                cursor = 0;
                return;
            end
            child = node_cnt;
            node_cnt++;
            trie_next[cursor * 256 + s] = child[11:0];
        end
        cursor = child;
        if (fin) begin
            if (term_cnt[child] != 11'h7ff) term_cnt[child]++;
            term_slot[child] = pid[9:0];
            cursor = 0;
        end
    endfunction

    function void build_links();
        int bfs [$];
        int p, f, c, t;
        cursor = 0;
        found = 0;
        foreach (slot_seen[i]) slot_seen[i] = 0;
        if (built) return;
        built = 1;
        for (int i = 0; i < 256; i++) begin
            c = edge_to(0, i);
            if (c != 0) begin
                fail_of[c] = '0;
                bfs.push_back(c);
            end
        end
        while (bfs.size() > 0) begin
            p = bfs.pop_front();
            f = fail_of[p];
            for (int i = 0; i < 256; i++) begin
                c = edge_to(p, i);
                t = edge_to(f, i);
                if (c != 0) begin
                    fail_of[c] = t[11:0];
                    bfs.push_back(c);
                end else if (t != 0) begin
                    trie_next[p * 256 + i] = t[11:0];
                end
            end
        end
    endfunction

    function void step_text(int s);
        int t;
        cursor = edge_to(cursor, s);
        t = cursor;
        for (int k = 0; k < 4096; k++) begin
            if (term_cnt[t] != 0 && !slot_seen[term_slot[t]]) begin
                found += term_cnt[t];
                if (found > 2047) found = 2047;
                slot_seen[term_slot[t]] = 1;
            end
            if (t == 0) break;
            t = fail_of[t];
        end
    endfunction

    // one accepted input item
    function void note_item(logic [1:0] cmd, logic [7:0] sym, logic [10:0] pid, bit fin);
        t_match_res r;
        case (cmd)
            mpbm_pkg::CMD_CLEAR:   wipe();
            mpbm_pkg::CMD_PATTERN: insert_sym(sym, pid, fin);
            mpbm_pkg::CMD_BUILD:   build_links();
            default: begin
                step_text(sym);
                if (fin) begin
                    r.count = found[10:0];
                    r.ovf = full;
                    pending_q.push_back(r);
                    found = 0;
                    cursor = 0;
                    foreach (slot_seen[i]) slot_seen[i] = 0;
                end
            end
        endcase
    endfunction

    function void check_result(logic [10:0] count, logic ovf);
        t_match_res e;
        n_results++;
        if (count != 0) n_hits++;
        if (pending_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: unexpected result count=%0d overflow=%0b", count, ovf);
            return;
        end
        e = pending_q.pop_front();
        if (e.count !== count || e.ovf !== ovf) begin
            n_errors++;
            if (n_errors <= 10)
                $display("ERROR: result %0d: expected count=%0d overflow=%0b, got %0d/%0b",
                         n_results, e.count, e.ovf, count, ovf);
        end
    endfunction
endclass

module tb_multi_pattern_byte_matcher_core;
    import mpbm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // the clear sweep of the goto memory is the longest quiet stretch
    localparam int STALL_LIMIT = 5_000_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [1:0]       i_cmd;
    logic [7:0]       i_data_byte;
    logic [PID_W-1:0] i_pattern_id;
    logic             i_last;
    logic             o_valid;
    logic             i_stall;
    logic [CNT_W-1:0] o_match_count;
    logic             o_overflow;

    match_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  quiet_cycles;
    int  n_items;
    logic [7:0] sym_set [4];

    multi_pattern_byte_matcher_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_data_byte   (i_data_byte),
        .i_pattern_id  (i_pattern_id),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_match_count (o_match_count),
        .o_overflow    (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // idling mix: none, sender, receiver, both
    task automatic set_mode(int m);
        case (m % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    task automatic send_item(logic [1:0] cmd, logic [7:0] sym, logic [10:0] pid, bit fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_data_byte  <= sym;
        i_pattern_id <= pid;
        i_last       <= fin;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(cmd, sym, pid, fin);
        n_items++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [10:0] rand_pid();
        return 11'($urandom_range(1, 1024));
    endfunction

    function automatic logic [7:0] rand_sym();
        return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : sym_set[$urandom_range(3)];
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // results side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_match_count, o_overflow);
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("multi_pattern_byte_matcher_core test failed");
            $finish;
        end
    end

    initial begin
        int plen, tlen;
        sb = new();
        quiet_cycles = 0;
        n_items = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_stall      <= 1'b0;
        i_cmd        <= CMD_CLEAR;
        i_data_byte  <= '0;
        i_pattern_id <= '0;
        i_last       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: duplicates, shared slots, text before and after build
        set_mode(0);
        send_item(CMD_PATTERN, "a", 11'd1, 0);
        send_item(CMD_PATTERN, "b", 11'd1, 1);
        send_item(CMD_PATTERN, "b", 11'd1024, 1);
        send_item(CMD_PATTERN, "a", 11'd2, 0);
        send_item(CMD_PATTERN, "b", 11'd2, 1);
        send_item(CMD_PATTERN, 8'hff, 11'd1023, 0);
        send_item(CMD_PATTERN, 8'h00, 11'd1023, 1);
        send_item(CMD_PATTERN, "a", 11'd7, 0);      // text continues from mid pattern
        send_item(CMD_TEXT, "b", 11'd0, 1);
        send_item(CMD_TEXT, "a", 11'd0, 0);         // text before build
        send_item(CMD_TEXT, "b", 11'd0, 1);
        send_item(CMD_PATTERN, "c", 11'd9, 0);      // build in mid pattern
        send_item(CMD_BUILD, 8'h00, 11'd0, 0);
        send_item(CMD_BUILD, 8'h00, 11'd0, 0);
        send_item(CMD_PATTERN, "z", 11'd3, 1);      // ignored after build
        send_item(CMD_TEXT, "x", 11'd0, 0);
        send_item(CMD_TEXT, "a", 11'd0, 0);
        send_item(CMD_TEXT, "b", 11'd0, 0);
        send_item(CMD_TEXT, 8'hff, 11'd0, 0);
        send_item(CMD_TEXT, 8'h00, 11'd0, 1);
        send_item(CMD_TEXT, "b", 11'd0, 1);
        send_item(CMD_TEXT, "z", 11'd2047, 1);
        drain();

        // random pattern set over a few symbols, then many texts
        for (int i = 0; i < 4; i++) sym_set[i] = 8'($urandom_range(255));
        send_item(CMD_CLEAR, 8'h00, 11'd0, 0);
        for (int p = 0; p < 40; p++) begin
            set_mode(p / 10);
            plen = $urandom_range(1, 4);
            for (int k = 0; k < plen; k++)
                send_item(CMD_PATTERN, rand_sym(), rand_pid(), k == plen - 1);
        end
        send_item(CMD_BUILD, 8'($urandom_range(255)), rand_pid(), rand_bit());
        while (n_items < 1700) begin
            set_mode(n_items / 100);
            if (n_items > 900 && n_items < 930) begin
                drain();                            // hold off until all results are in
            end
            case ($urandom_range(19))
                0: send_item(CMD_PATTERN, 8'($urandom_range(255)), rand_pid(), rand_bit());
                1: send_item(CMD_BUILD, 8'($urandom_range(255)), rand_pid(), rand_bit());
                default: begin
                    tlen = $urandom_range(1, 24);
                    for (int k = 0; k < tlen; k++)
                        send_item(CMD_TEXT, rand_sym(), 11'($urandom_range(2047)),
                                  k == tlen - 1);
                end
            endcase
        end
        drain();
        repeat (3000) @(posedge i_clk);

        $display("%0d items sent, %0d match counts checked (%0d non-zero)",
                 n_items, sb.n_results, sb.n_hits);
        $display("covered clear, insert, rebuild, text before and after build; %0d errors",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_q.size() == 0)
            $display("multi_pattern_byte_matcher_core test passed");
        else
            $display("multi_pattern_byte_matcher_core test failed");
        $finish;
    end
endmodule

`default_nettype wire
